// ===== rtl/csf_pkg.sv =====
// csf_pkg: shared types and constants for the covalent structure filter.
// Holds the configuration record, the entry flags passed front to back and
// the result word. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

    // Orbital field, configuration port widths and queue depth
    localparam int unsigned ORB_W       = 6;
    localparam int unsigned ORB_SPAN    = 64;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_EMPTY   = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_TOTAL  = 2'd1,
        REG_ACTIVE = 2'd2,
        REG_COUNT  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  total_electrons;
        logic [7:0]  active_electrons;
        logic [15:0] structure_count;
    } cfg_t;

    // Classification of one entry, made by the front end
    typedef struct packed {
        logic in_window;
        logic last_entry;
        logic invalid;
        logic covalent;
    } entry_flags_t;

    typedef struct packed {
        logic [15:0] structure_number;
        logic        keep;
        status_t     status;
        logic        final_res;
    } result_t;

endpackage : csf_pkg

`default_nettype wire

// ===== rtl/covalent_structure_filter.sv =====
// Covalent structure filter: one orbital word accepted per cycle while full is
// low, one result word per structure. A result is visible (empty low) after
// the back end pushes it into the result queue at its structure's last word.
// Throughput: one word per cycle, set by the combinational bitmap test in the
// back end; stalls only while the result queue is full at a structure end.
// Reset (rst_n, asynchronous): registers to defaults, queues empty, bitmap clear.
`timescale 1ns / 1ps
`default_nettype none

module covalent_structure_filter
    import csf_pkg::*;
#(
    parameter int unsigned MAX_ORBITALS = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [ORB_W-1:0]       orbital,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [15:0]                 structure_number,
    output logic                        keep,
    output logic [1:0]                  status,
    output logic                        final_res,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned IDX_W   = $clog2(MAX_ORBITALS);
    localparam int unsigned FLAGS_W = $bits(entry_flags_t);
    localparam int unsigned MID_W   = IDX_W + FLAGS_W;
    localparam int unsigned RES_W   = $bits(result_t);

    cfg_t             cfg_reg, cfg_next;
    logic             accept;
    logic [IDX_W-1:0] front_index;
    entry_flags_t     front_flags;
    logic [MID_W-1:0] mid_word;
    logic             mid_empty;
    logic             mid_pop;
    logic [IDX_W-1:0] back_index;
    entry_flags_t     back_flags;
    logic             out_full;
    logic             out_push;
    result_t          back_result;
    result_t          out_word;
    logic [RES_W-1:0] out_bits;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (reg_index_t'(cfg_index))
                REG_MODE:   cfg_next.mode             = cfg_data[0];
                REG_TOTAL:  cfg_next.total_electrons  = cfg_data[7:0];
                REG_ACTIVE: cfg_next.active_electrons = cfg_data[7:0];
                REG_COUNT:  cfg_next.structure_count  = cfg_data[15:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= 1'b0;
            cfg_reg.total_electrons  <= 8'd1;
            cfg_reg.active_electrons <= 8'd1;
            cfg_reg.structure_count  <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign accept = push && !full;

    // Front end: position and window classification
    csf_front #(
        .MAX_ORBITALS(MAX_ORBITALS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .orbital   (orbital),
        .bit_index (front_index),
        .flags     (front_flags)
    );

    // Queue between front and back
    csf_fifo #(
        .WIDTH(MID_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .data_in  ({front_index, front_flags}),
        .full     (full),
        .pop      (mid_pop),
        .data_out (mid_word),
        .empty    (mid_empty)
    );

    assign back_index = mid_word[MID_W-1:FLAGS_W];
    assign back_flags = entry_flags_t'(mid_word[FLAGS_W-1:0]);

    // Back end: bitmap and result
    csf_back #(
        .MAX_ORBITALS(MAX_ORBITALS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (!mid_empty),
        .bit_index (back_index),
        .flags     (back_flags),
        .q_pop     (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .result    (back_result)
    );

    // Result queue
    csf_fifo #(
        .WIDTH(RES_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .data_in  (back_result),
        .full     (out_full),
        .pop      (pop),
        .data_out (out_bits),
        .empty    (empty)
    );

    assign out_word         = result_t'(out_bits);
    assign structure_number = out_word.structure_number;
    assign keep             = out_word.keep;
    assign status           = out_word.status;
    assign final_res        = out_word.final_res;

endmodule : covalent_structure_filter

`default_nettype wire

// ===== rtl/csf_fifo.sv =====
// csf_fifo: small register queue with separate push/pop sides.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module csf_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] data_in,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      data_out,
    output logic                  empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = store_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule : csf_fifo

`default_nettype wire

// ===== rtl/csf_front.sv =====
// csf_front: entry position tracking and window classification.
// Depends on csf_pkg for the configuration and entry flag types.
`timescale 1ns / 1ps
`default_nettype none

module csf_front
    import csf_pkg::*;
#(
    parameter int unsigned MAX_ORBITALS = 64,
    localparam int unsigned IDX_W = $clog2(MAX_ORBITALS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             accept,
    input  wire logic [ORB_W-1:0] orbital,
    output logic [IDX_W-1:0]      bit_index,
    output entry_flags_t          flags
);

    logic [7:0]     entry_position_reg, entry_position_next;
    logic [8:0]     len;
    logic [8:0]     act;
    logic [8:0]     span;
    logic [8:0]     start;
    logic [8:0]     stop;
    logic [8:0]     pos;
    logic           counts_bad;
    logic           window_bad;
    logic [IDX_W-1:0] mod_table [ORB_SPAN];

    // Orbital index folded onto the bitmap width, fixed at elaboration
    for (genvar g = 0; g < ORB_SPAN; g++)
    begin : g_mod
        assign mod_table[g] = IDX_W'(g % MAX_ORBITALS);
    end

    assign bit_index = mod_table[orbital];

    // Window bounds from the current register values
    assign len        = (cfg.total_electrons == 8'd0) ? 9'd256 : {1'b0, cfg.total_electrons};
    assign act        = {1'b0, cfg.active_electrons};
    assign counts_bad = (cfg.total_electrons == 8'd0) || (cfg.active_electrons == 8'd0);
    assign window_bad = (act > len);
    assign span       = len - act;
    assign start      = window_bad ? 9'd0 : {span[8:1], 1'b0};
    assign stop       = start + act;
    assign pos        = {1'b0, entry_position_reg};

    // Classification of the entry on the input
    always_comb
    begin
        flags.in_window  = (pos >= start) && (pos < stop);
        flags.last_entry = ((pos + 9'd1) >= len);
        flags.covalent   = cfg.mode;
        flags.invalid    = counts_bad || (cfg.mode && window_bad);
    end

    // Entry position advances on every accepted word and returns to zero after the last entry
    always_comb
    begin
        entry_position_next = entry_position_reg;
        if (accept)
        begin
            entry_position_next = flags.last_entry ? 8'd0 : entry_position_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_position_reg <= '0;
        end
        else
        begin
            entry_position_reg <= entry_position_next;
        end
    end

endmodule : csf_front

`default_nettype wire

// ===== rtl/csf_back.sv =====
// csf_back: repeat detection on the seen bitmap and result formation.
// Depends on csf_pkg for configuration, entry flag and result types.
`timescale 1ns / 1ps
`default_nettype none

module csf_back
    import csf_pkg::*;
#(
    parameter int unsigned MAX_ORBITALS = 64,
    localparam int unsigned IDX_W = $clog2(MAX_ORBITALS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             q_valid,
    input  wire logic [IDX_W-1:0] bit_index,
    input  wire entry_flags_t     flags,
    output logic                  q_pop,
    input  wire logic             out_full,
    output logic                  out_push,
    output result_t               result
);

    logic [MAX_ORBITALS-1:0] seen_reg, seen_next;
    logic [MAX_ORBITALS-1:0] seen_set;
    logic [15:0]             structure_counter_reg, structure_counter_next;
    logic                    repeat_found_reg, repeat_found_next;
    logic                    any_kept_reg, any_kept_next;
    logic                    fire;
    logic                    hit;
    logic                    repeat_now;
    logic                    keep_now;
    logic                    kept_any;
    logic                    last_struct;
    logic [16:0]             cnt;

    // A word moves unless it ends a structure and the result queue is full
    assign fire     = q_valid && !(flags.last_entry && out_full);
    assign q_pop    = fire;
    assign out_push = fire && flags.last_entry;

    // Bitmap test
    always_comb
    begin
        seen_set            = '0;
        seen_set[bit_index] = flags.in_window;
    end

    assign hit        = flags.in_window && seen_reg[bit_index];
    assign repeat_now = repeat_found_reg || hit;

    // Structure verdict
    assign cnt         = (cfg.structure_count == 16'd0) ? 17'h10000
                                                        : {1'b0, cfg.structure_count};
    assign last_struct = (({1'b0, structure_counter_reg} + 17'd1) >= cnt);
    assign keep_now    = !flags.invalid && (!flags.covalent || !repeat_now);
    assign kept_any    = any_kept_reg || keep_now;

    always_comb
    begin
        result.structure_number = structure_counter_reg;
        result.keep             = keep_now;
        result.final_res        = last_struct;
        if (flags.invalid)
        begin
            result.status = STATUS_INVALID;
        end
        else if (flags.covalent && last_struct && !kept_any)
        begin
            result.status = STATUS_EMPTY;
        end
        else
        begin
            result.status = STATUS_OK;
        end
    end

    // State update
    always_comb
    begin
        seen_next              = seen_reg;
        repeat_found_next      = repeat_found_reg;
        structure_counter_next = structure_counter_reg;
        any_kept_next          = any_kept_reg;
        if (fire)
        begin
            if (flags.last_entry)
            begin
                seen_next         = '0;
                repeat_found_next = 1'b0;
                if (last_struct)
                begin
                    structure_counter_next = '0;
                    any_kept_next          = 1'b0;
                end
                else
                begin
                    structure_counter_next = structure_counter_reg + 16'd1;
                    any_kept_next          = kept_any;
                end
            end
            else
            begin
                seen_next         = seen_reg | seen_set;
                repeat_found_next = repeat_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg              <= '0;
            repeat_found_reg      <= 1'b0;
            structure_counter_reg <= '0;
            any_kept_reg          <= 1'b0;
        end
        else
        begin
            seen_reg              <= seen_next;
            repeat_found_reg      <= repeat_found_next;
            structure_counter_reg <= structure_counter_next;
            any_kept_reg          <= any_kept_next;
        end
    end

`ifndef SYNTH
    // Stream end returns the structure counter to zero
    a_final_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        out_push && result.final_res |=> structure_counter_reg == '0)
        else $error("structure counter not cleared after final structure");

    // Bitmap is clear at the start of every structure
    a_seen_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        fire && flags.last_entry |=> seen_reg == '0 && !repeat_found_reg)
        else $error("seen bitmap not cleared at structure end");

    // Counter only moves at a structure end
    a_counter_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && flags.last_entry) |=> $stable(structure_counter_reg))
        else $error("structure counter moved mid-structure");

    // A flagged structure is never kept
    a_status_no_keep: assert property (@(posedge clk) disable iff (!rst_n)
        out_push && result.status != STATUS_OK |-> !result.keep)
        else $error("structure kept with non-ok status");
`endif

endmodule : csf_back

`default_nettype wire

// ===== tb/sv/covalent_structure_filter_tb.sv =====
// Self-checking testbench for the covalent structure filter.
// Drives orbital words through the push/full queue, predicts each result word
// and checks it against the pop/empty side. Depends on csf_pkg and the RTL.
`timescale 1ns / 1ps

module covalent_structure_filter_tb;
    import csf_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned TIMEOUT_NS   = 5_000_000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [ORB_W-1:0]       orbital = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [15:0]            structure_number;
    logic                   keep;
    logic [1:0]             status;
    logic                   final_res;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow registers and filter state, as the block should hold them
    cfg_t        shadow = '{mode: 1'b0, total_electrons: 8'd1, active_electrons: 8'd1,
                            structure_count: 16'd1};
    logic [63:0] seen_map = '0;
    logic [7:0]  entry_pos = '0;
    logic [15:0] struct_idx = '0;
    bit          dup_found = 1'b0;
    bit          kept_any = 1'b0;

    result_t     pending_results[$];

    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned settings_applied = 0;
    int unsigned fail_count = 0;

    // Sender burst shaping and receiver hold-off request
    int unsigned burst_left = 0;
    int unsigned gap_max = 6;
    bit          hold_req = 1'b0;

    covalent_structure_filter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .orbital          (orbital),
        .empty            (empty),
        .pop              (pop),
        .structure_number (structure_number),
        .keep             (keep),
        .status           (status),
        .final_res        (final_res),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Advance the filter by one orbital word; queue a result at structure end
    task automatic track_orbital(input logic [ORB_W-1:0] orb);
        int unsigned len;
        int unsigned cnt;
        int unsigned act;
        int unsigned start;
        int unsigned stop;
        bit          counts_bad;
        bit          window_bad;
        bit          invalid;
        bit          last_struct;
        result_t     res;
        len = (shadow.total_electrons == 0) ? 256 : shadow.total_electrons;
        cnt = (shadow.structure_count == 0) ? 65536 : shadow.structure_count;
        act = shadow.active_electrons;
        counts_bad = (shadow.total_electrons == 0) || (act == 0);
        window_bad = act > len;
        start = window_bad ? 0 : 2 * ((len - act) / 2);
        stop = start + act;
        // only the active window marks the bitmap; index wraps at the span
        if (entry_pos >= start && entry_pos < stop)
        begin
            if (seen_map[orb % ORB_SPAN])
                dup_found = 1'b1;
            seen_map[orb % ORB_SPAN] = 1'b1;
        end
        if (entry_pos + 1 < len)
        begin
            entry_pos = entry_pos + 8'd1;
            return;
        end
        // structure complete
        last_struct = (struct_idx + 1) >= cnt;
        invalid = counts_bad || (shadow.mode && window_bad);
        res.structure_number = struct_idx;
        res.final_res = last_struct;
        res.status = STATUS_OK;
        if (invalid)
        begin
            res.keep = 1'b0;
            res.status = STATUS_INVALID;
        end
        else if (!shadow.mode)
            res.keep = 1'b1;
        else
            res.keep = !dup_found;
        if (res.keep)
            kept_any = 1'b1;
        if (!invalid && shadow.mode && last_struct && !kept_any)
            res.status = STATUS_EMPTY;
        pending_results = {pending_results, res};
        seen_map = '0;
        dup_found = 1'b0;
        entry_pos = '0;
        if (last_struct)
        begin
            struct_idx = '0;
            kept_any = 1'b0;
        end
        else
            struct_idx = struct_idx + 16'd1;
    endtask

    // Offer one word, in bursts with random gaps, and wait for it to be taken
    task automatic send_orbital(input logic [ORB_W-1:0] orb);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap_max > 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        orbital <= orb;
        do
            @(posedge clk);
        while (full);
        track_orbital(orb);
        items_sent++;
    endtask

    // Stop offering, let every expected word out and the pipeline settle
    task automatic drain_block();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back while the block is idle
    task automatic set_config(input bit m, input logic [7:0] tot, input logic [7:0] act,
                              input logic [15:0] cnt);
        reg_index_t order[4];
        order = '{REG_MODE, REG_TOTAL, REG_ACTIVE, REG_COUNT};
        drain_block();
        foreach (order[i])
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= order[i];
            case (order[i])
                REG_MODE:   cfg_data <= {{(CFG_DATA_W-1){1'b0}}, m};
                REG_TOTAL:  cfg_data <= {8'd0, tot};
                REG_ACTIVE: cfg_data <= {8'd0, act};
                REG_COUNT:  cfg_data <= cnt;
                default:    cfg_data <= '0;
            endcase
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        shadow.mode = m;
        shadow.total_electrons = tot;
        shadow.active_electrons = act;
        shadow.structure_count = cnt;
        settings_applied++;
    endtask

    // Whole structures; clean ones use an odd stride so no orbital repeats
    task automatic send_structures(input int n_struct, input int len, input int clean_pct);
        int base;
        int stride;
        bit clean;
        bit narrow;
        repeat (n_struct)
        begin
            clean = $urandom_range(0, 99) < clean_pct;
            narrow = 1'($urandom_range(0, 1));
            base = $urandom_range(0, 63);
            stride = 2 * $urandom_range(0, 31) + 1;
            for (int p = 0; p < len; p++)
            begin
                if (clean)
                    send_orbital(ORB_W'((base + p * stride) % ORB_SPAN));
                else if (narrow)
                    send_orbital(ORB_W'($urandom_range(0, 7)));
                else
                    send_orbital(ORB_W'($urandom_range(0, 63)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_orbital(6'd63);
    endtask

    task automatic test_window_rules();
        // window wider than the structure: rejected in covalent mode only
        set_config(1'b1, 8'd2, 8'd3, 16'd2);
        send_orbital(6'd10); send_orbital(6'd20); send_orbital(6'd30); send_orbital(6'd40);
        set_config(1'b0, 8'd2, 8'd3, 16'd1);
        send_orbital(6'd0); send_orbital(6'd0);
        // empty window is always invalid
        set_config(1'b0, 8'd1, 8'd0, 16'd1);
        send_orbital(6'd5);
        // window sits at entries 2 and 3; the repeat there empties the stream
        set_config(1'b1, 8'd5, 8'd2, 16'd1);
        send_orbital(6'd1); send_orbital(6'd2); send_orbital(6'd9);
        send_orbital(6'd9); send_orbital(6'd1);
    endtask

    task automatic test_covalent_selection();
        set_config(1'b1, 8'd2, 8'd2, 16'd2);
        send_orbital(6'd0); send_orbital(6'd63);
        send_orbital(6'd63); send_orbital(6'd63);
    endtask

    task automatic test_stream_control();
        // zero count runs on; a smaller count then closes the stream at once
        set_config(1'b0, 8'd1, 8'd1, 16'd0);
        send_orbital(6'd3); send_orbital(6'd4); send_orbital(6'd5);
        set_config(1'b0, 8'd1, 8'd1, 16'd2);
        send_orbital(6'd6);
        // shortening the structure mid-way ends it at the next word
        set_config(1'b0, 8'd4, 8'd1, 16'd1);
        send_orbital(6'd7); send_orbital(6'd8);
        set_config(1'b0, 8'd2, 8'd1, 16'd1);
        send_orbital(6'd9);
    endtask

    // Receiver holds off while the sender keeps pushing, so full must rise
    task automatic test_backpressure();
        set_config(1'b0, 8'd1, 8'd1, 16'd16);
        gap_max = 0;
        hold_req = 1'b1;
        repeat (24) send_orbital(ORB_W'($urandom_range(0, 63)));
        hold_req = 1'b0;
        gap_max = 6;
    endtask

    task automatic test_structure_extremes();
        set_config(1'b1, 8'd255, 8'd64, 16'd65535);
        send_structures(1, 255, 100);
        // zero total means 256 entries and an invalid window
        set_config(1'b0, 8'd0, 8'd1, 16'd1);
        send_structures(1, 256, 50);
    endtask

    task automatic test_random_streams();
        int unsigned first;
        int          tot;
        int          act;
        int          cnt;
        bit          m;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            m = 1'($urandom_range(0, 1));
            tot = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            case ($urandom_range(0, 9))
                0:       act = 0;
                1:       act = $urandom_range(tot + 1, 255);
                2:       act = 255;
                default: act = $urandom_range(1, tot);
            endcase
            cnt = $urandom_range(1, 6);
            set_config(m, 8'(tot), 8'(act), 16'(cnt));
            send_structures(cnt, tot, m ? 60 : 30);
            // now and then leave a structure half done for the next setting
            if (tot > 1 && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, tot - 1))
                    send_orbital(ORB_W'($urandom_range(0, 63)));
        end
    endtask

    // Receiver: alternating ready and stall runs, plus a long hold on request
    int unsigned hold_count = 0;
    int unsigned rx_left = 0;
    bit          rx_ready = 1'b0;

    always @(posedge clk)
    begin
        if (!hold_req)
            hold_count = 0;
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            pop <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_ready = !rx_ready;
                if (rx_ready)
                    rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                          : $urandom_range(1, 10);
                else
                    rx_left = $urandom_range(1, 8);
            end
            rx_left--;
            pop <= rx_ready;
        end
    end

    // Compare each popped word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: structure_number %0d", structure_number);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (structure_number !== want.structure_number)
                begin
                    $error("structure_number mismatch: expected %0d, got %0d",
                           want.structure_number, structure_number);
                    fail_count++;
                end
                if (keep !== want.keep)
                begin
                    $error("keep mismatch: expected %0d, got %0d", want.keep, keep);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (final_res !== want.final_res)
                begin
                    $error("final_res mismatch: expected %0d, got %0d",
                           want.final_res, final_res);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_window_rules();
        test_covalent_selection();
        test_stream_control();
        test_backpressure();
        test_structure_extremes();
        test_random_streams();
        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d orbital words, checked %0d result words over %0d register settings,",
                 items_sent, results_checked, settings_applied);
        $display("including back-pressure, long structures and mid-structure changes.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result words outstanding", pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/csf_pkg.sv
rtl/csf_fifo.sv
rtl/csf_front.sv
rtl/csf_back.sv
rtl/covalent_structure_filter.sv
tb/sv/covalent_structure_filter_tb.sv
